// ===== rtl/rmt_pkg.sv =====
// Package for the running median tracker: field widths and the default capacity.
// No dependencies; used by rmt_cell and running_median_tracker_top.
package rmt_pkg;

	localparam int SAMPLE_W         = 32;
	localparam int MEDIAN_W         = 33;
	localparam int COUNT_W          = 7;
	localparam int DEFAULT_CAPACITY = 64;

endpackage

// ===== rtl/rmt_cell.sv =====
// One cell of the sorted insertion chain: holds one sample and shifts right on insert.
// Depends on rmt_pkg.
module rmt_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 7
) (
	input  logic                                clk,
	input  logic                                ins,
	input  logic signed [rmt_pkg::SAMPLE_W-1:0] sample,
	input  logic        [CNT_W-1:0]             count,
	input  logic signed [rmt_pkg::SAMPLE_W-1:0] left_value,
	input  logic                                left_gt,
	output logic signed [rmt_pkg::SAMPLE_W-1:0] value,
	output logic                                gt
);

	logic signed [rmt_pkg::SAMPLE_W-1:0] value_q;
	logic                                occupied;
	logic                                at_end;

	assign occupied = CNT_W'(INDEX) < count;
	assign at_end   = CNT_W'(INDEX) == count;

	// The first free cell acts as plus infinity, so the new sample lands there
	// when it is not below any held sample. Equal samples stay to the left.
	assign gt    = at_end | (occupied & (value_q > sample));
	assign value = value_q;

	always_ff @(posedge clk) begin
		if (ins && gt) begin
			value_q <= left_gt ? left_value : sample;
		end
	end

endmodule

// ===== rtl/running_median_tracker_top.sv =====
// Top level of the running median tracker: control sequencer, cell chain and output register.
// Depends on rmt_pkg and rmt_cell.

// Usage
// The input channel (in_valid, in_ready, sample) carries one signed 32-bit sample
// per transfer. The output channel (out_valid, out_ready, median_twice,
// sample_count, rejected) returns exactly one result per input transfer, in order.
// Each result gives twice the median of all samples held, the number held, and a
// flag that is set when the store was already full and the sample was dropped.
// Samples live in a chain of CAPACITY cells kept in ascending order; an insert
// moves every cell above the new sample one place to the right at the transfer edge.
// An item passes through the sequencer steps in order: the insert at the transfer
// edge, the pick of the two middle cells out of the chain into registers, and
// their sum into the output register. A new sample is taken only once the
// sequencer is back in its idle state, so the block takes no new sample until it
// has loaded the result of the last one into the output register and out_valid.
// A result waiting on a stalled receiver does not block the next input; the
// sequencer only holds in its last step while the output register is still full.
// Reset clears the sample count, the sequencer and out_valid; cell contents are
// not cleared, since only cells below the count are ever read.
module running_median_tracker_top #(
	parameter int CAPACITY = rmt_pkg::DEFAULT_CAPACITY
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [rmt_pkg::SAMPLE_W-1:0] sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [rmt_pkg::MEDIAN_W-1:0] median_twice,
	output logic        [rmt_pkg::COUNT_W-1:0]  sample_count,
	output logic                                rejected
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SELECT,
		ST_SUM
	} state_t;

	state_t                              state_q;
	logic        [CNT_W-1:0]             count_q;
	logic                                rej_q;
	logic signed [rmt_pkg::SAMPLE_W-1:0] lo_q;
	logic signed [rmt_pkg::SAMPLE_W-1:0] hi_q;
	logic                                out_valid_q;
	logic signed [rmt_pkg::MEDIAN_W-1:0] median_q;
	logic        [rmt_pkg::COUNT_W-1:0]  count_out_q;
	logic                                rejected_q;

	logic                                in_xfer;
	logic                                full;
	logic                                ins;
	logic                                out_load;
	logic        [CNT_W-1:0]             hi_idx;
	logic        [CNT_W-1:0]             lo_idx;
	logic signed [rmt_pkg::SAMPLE_W-1:0] lo_sel;
	logic signed [rmt_pkg::SAMPLE_W-1:0] hi_sel;
	logic        [CNT_W+rmt_pkg::COUNT_W-1:0] count_wide;

	logic signed [rmt_pkg::SAMPLE_W-1:0] cell_val [CAPACITY];
	logic                                cell_gt  [CAPACITY];

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign ins      = in_xfer && !full;

	// The output register takes a new result in the last step once it is empty
	// or its current result leaves in the same cycle.
	assign out_load = (state_q == ST_SUM) && (!out_valid_q || out_ready);

	// The sorted chain. Cell zero has no left neighbor that could shift in.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [rmt_pkg::SAMPLE_W-1:0] left_value;
		logic                                left_gt;

		if (i == 0) begin : g_first
			assign left_value = '0;
			assign left_gt    = 1'b0;
		end else begin : g_rest
			assign left_value = cell_val[i-1];
			assign left_gt    = cell_gt[i-1];
		end

		rmt_cell #(
			.INDEX (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk        (clk),
			.ins        (ins),
			.sample     (sample),
			.count      (count_q),
			.left_value (left_value),
			.left_gt    (left_gt),
			.value      (cell_val[i]),
			.gt         (cell_gt[i])
		);
	end

	// Middle positions for the count after the insert. The count is at least one
	// here, since the first item always finds room.
	assign hi_idx = count_q >> 1;
	assign lo_idx = count_q[0] ? hi_idx : hi_idx - CNT_W'(1);

	always_comb begin
		lo_sel = '0;
		hi_sel = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (CNT_W'(i) == lo_idx) begin
				lo_sel = lo_sel | cell_val[i];
			end
			if (CNT_W'(i) == hi_idx) begin
				hi_sel = hi_sel | cell_val[i];
			end
		end
	end

	// The count field is the held count reduced to seven bits.
	assign count_wide = {{rmt_pkg::COUNT_W{1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						rej_q   <= full;
						state_q <= ST_SELECT;
						if (!full) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				ST_SELECT: begin
					lo_q    <= lo_sel;
					hi_q    <= hi_sel;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (out_load) begin
						median_q    <= rmt_pkg::MEDIAN_W'(lo_q) + rmt_pkg::MEDIAN_W'(hi_q);
						count_out_q <= count_wide[rmt_pkg::COUNT_W-1:0];
						rejected_q  <= rej_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign median_twice = median_q;
	assign sample_count = count_out_q;
	assign rejected     = rejected_q;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for running_median_tracker_top: a directed table of samples,
// then random samples with bursty input and a stalling receiver, checked against a predictor.
// Depends on rmt_pkg and the RTL of running_median_tracker_top.
module testbench;

	localparam int CAP            = rmt_pkg::DEFAULT_CAPACITY;
	localparam int RANDOM_ITEMS   = 600;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 12;
	localparam int ROWS           = 22;

	// One result as the block reports it.
	typedef struct packed {
		logic signed [rmt_pkg::MEDIAN_W-1:0] median;
		logic [rmt_pkg::COUNT_W-1:0]         count;
		logic                                rej;
	} median_result_t;

	// One line of the directed table. Where fixed is set, the result is typed in here
	// and the table value is what gets checked; otherwise the predictor supplies it.
	typedef struct packed {
		logic signed [rmt_pkg::SAMPLE_W-1:0] value;
		logic                                fixed;
		median_result_t                      want;
	} sample_row_t;

	// Receiver behavior, picked anew at random whenever the current mode has run its course.
	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                in_valid = 1'b0;
	logic                                in_ready;
	logic signed [rmt_pkg::SAMPLE_W-1:0] sample = '0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic signed [rmt_pkg::MEDIAN_W-1:0] median_twice;
	logic [rmt_pkg::COUNT_W-1:0]         sample_count;
	logic                                rejected;

	// Side-band for the directed table: travels with the sample so that the monitor
	// knows whether a typed-in result applies to the transfer it sees.
	logic                                row_fixed = 1'b0;
	median_result_t                      row_want = '0;

	// Predictor state: its own sorted copy of the samples and the number held.
	logic signed [rmt_pkg::SAMPLE_W-1:0] sorted_copy [0:CAP-1];
	int unsigned                         held_samples = 0;

	median_result_t                      median_q[$];
	logic signed [rmt_pkg::SAMPLE_W-1:0] sent_history[$];

	int unsigned errors = 0;
	int unsigned results_seen = 0;
	int unsigned rejects_seen = 0;
	int unsigned idle_cycles = 0;
	int unsigned burst_left = 0;
	bit          steady_input = 1'b0;

	rx_mode_t    rx_mode = RX_OPEN;
	int unsigned rx_left = 0;
	int unsigned rx_phase = 0;

	// The first rows start from an empty store with both extremes, so their medians
	// can be worked out by hand. The rest cover equal samples, alternating bit patterns
	// and values around zero, and are left to the predictor.
	sample_row_t stim_rows [0:ROWS-1] = '{
		'{32'h8000_0000, 1'b1, '{33'h1_0000_0000, 7'd1, 1'b0}},
		'{32'h7FFF_FFFF, 1'b1, '{33'h1_FFFF_FFFF, 7'd2, 1'b0}},
		'{32'h0000_0000, 1'b1, '{33'h0_0000_0000, 7'd3, 1'b0}},
		'{32'h0000_0000, 1'b1, '{33'h0_0000_0000, 7'd4, 1'b0}},
		'{32'h7FFF_FFFF, 1'b1, '{33'h0_0000_0000, 7'd5, 1'b0}},
		'{32'h7FFF_FFFF, 1'b1, '{33'h0_7FFF_FFFF, 7'd6, 1'b0}},
		'{32'h7FFF_FFFF, 1'b1, '{33'h0_FFFF_FFFE, 7'd7, 1'b0}},
		'{32'h8000_0000, 1'b1, '{33'h0_7FFF_FFFF, 7'd8, 1'b0}},
		'{32'hFFFF_FFFF, 1'b0, '0},
		'{32'h0000_0001, 1'b0, '0},
		'{32'h0000_0005, 1'b0, '0},
		'{32'h0000_0005, 1'b0, '0},
		'{32'h0000_0005, 1'b0, '0},
		'{32'hFFFF_FFFB, 1'b0, '0},
		'{32'h5555_5555, 1'b0, '0},
		'{32'hAAAA_AAAA, 1'b0, '0},
		'{32'h0000_0064, 1'b0, '0},
		'{32'hFFFF_FF9C, 1'b0, '0},
		'{32'h7FFF_0000, 1'b0, '0},
		'{32'h8000_0001, 1'b0, '0},
		'{32'h0000_0002, 1'b0, '0},
		'{32'hFFFF_FFFE, 1'b0, '0}
	};

	running_median_tracker_top #(
		.CAPACITY(CAP)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.median_twice(median_twice),
		.sample_count(sample_count),
		.rejected(rejected)
	);

	// 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Inserts one sample into the predictor's sorted copy, after any equal values,
	// and returns the median pair sum, the count and the reject flag. A full store
	// leaves the copy untouched and repeats the current median.
	function automatic median_result_t median_track_step(
			input logic signed [rmt_pkg::SAMPLE_W-1:0] s);
		median_result_t                      res;
		int unsigned                         pos;
		logic signed [rmt_pkg::MEDIAN_W-1:0] lo;
		logic signed [rmt_pkg::MEDIAN_W-1:0] hi;
		res.rej = (held_samples >= CAP);
		if (!res.rej) begin
			pos = held_samples;
			while (pos > 0 && sorted_copy[pos-1] > s) begin
				sorted_copy[pos] = sorted_copy[pos-1];
				pos--;
			end
			sorted_copy[pos] = s;
			held_samples++;
		end
		if (held_samples == 0) begin
			res.median = '0;
		end else if (held_samples % 2 == 1) begin
			lo = sorted_copy[held_samples/2];
			res.median = lo + lo;
		end else begin
			lo = sorted_copy[held_samples/2 - 1];
			hi = sorted_copy[held_samples/2];
			res.median = lo + hi;
		end
		res.count = held_samples[rmt_pkg::COUNT_W-1:0];
		return res;
	endfunction

	// Random samples: full-range values, a cluster around zero, the extremes and
	// their neighbors, and repeats of earlier samples so that ties keep occurring.
	function automatic logic signed [rmt_pkg::SAMPLE_W-1:0] pick_sample();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick <= 3)
			return $urandom;
		if (pick <= 5)
			return $urandom_range(0, 64) - 32;
		if (pick == 6) begin
			case ($urandom_range(0, 4))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h0000_0000;
				3: return 32'hFFFF_FFFF;
				default: return 32'h0000_0001;
			endcase
		end
		if (pick <= 8 && sent_history.size() > 0)
			return sent_history[$urandom_range(0, sent_history.size() - 1)];
		if ($urandom_range(0, 1) == 1)
			return 32'h8000_0000 + $urandom_range(0, 8);
		return 32'h7FFF_FFFF - $urandom_range(0, 8);
	endfunction

	// Drives one sample at a falling edge and holds it until the transfer, then moves
	// to the next falling edge. Valid stays high here; the caller lowers it for a gap.
	task automatic send_sample(input logic signed [rmt_pkg::SAMPLE_W-1:0] s,
			input logic fixed, input median_result_t want);
		sample    = s;
		row_fixed = fixed;
		row_want  = want;
		in_valid  = 1'b1;
		sent_history.push_back(s);
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Burst control for the sender: after each burst, valid drops for a random number
	// of cycles unless a gap-free stretch is running.
	task automatic after_transfer();
		int unsigned gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = steady_input ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// Holds the sender off until every outstanding result has been returned.
	task automatic hold_until_drained();
		in_valid = 1'b0;
		while (median_q.size() != 0)
			@(negedge clk);
	endtask

	// Receiver: out_ready changes at falling edges. It alternates between always
	// ready, a coin toss per cycle, and a sparse pattern, ready only when its phase count is zero.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_left = $urandom_range(20, 80);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN: begin
				out_ready = 1'b1;
			end
			RX_COIN: begin
				out_ready = 1'($urandom_range(0, 1));
			end
			default: begin
				out_ready = (rx_phase == 0);
				rx_phase  = (rx_phase + 1) % 5;
			end
		endcase
	end

	// Monitor and checker. The input transfer is predicted before the output transfer
	// is compared, both in this one block, so the order of the two never depends on how
	// the simulator schedules processes within the same rising edge.
	always @(posedge clk) begin
		median_result_t predicted;
		median_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predicted = median_track_step(sample);
				median_q.push_back(row_fixed ? row_want : predicted);
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (rejected === 1'b1)
					rejects_seen++;
				if (median_q.size() == 0) begin
					errors++;
					$display({"%0t: result with nothing outstanding: ",
						"median_twice=%0d count=%0d rejected=%0b"},
						$time, median_twice, sample_count, rejected);
				end else begin
					want = median_q.pop_front();
					if (median_twice !== want.median) begin
						errors++;
						$display("%0t: median_twice expected %0d, got %0d",
							$time, want.median, median_twice);
					end
					if (sample_count !== want.count) begin
						errors++;
						$display("%0t: sample_count expected %0d, got %0d",
							$time, want.count, sample_count);
					end
					if (rejected !== want.rej) begin
						errors++;
						$display("%0t: rejected expected %0b, got %0b",
							$time, want.rej, rejected);
					end
				end
			end
		end
	end

	// Watchdog: any stretch with no transfer on either side that runs this long
	// means the block has hung.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("running_median_tracker_top verification failed");
			$finish;
		end
	end

	// Stimulus: reset, the directed table, a full drain, then random samples. The store
	// fills after its first CAP samples and every later sample must come back rejected
	// with the median and count frozen.
	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		burst_left = $urandom_range(1, 16);
		for (int i = 0; i < ROWS; i++) begin
			send_sample(stim_rows[i].value, stim_rows[i].fixed, stim_rows[i].want);
			after_transfer();
		end
		hold_until_drained();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// Two stretches run with no sender gaps at all, and the middle of the run
			// waits for a complete drain once more.
			steady_input = (i >= 150 && i < 230) || (i >= 450 && i < 500);
			if (i == 300)
				hold_until_drained();
			send_sample(pick_sample(), 1'b0, '0);
			after_transfer();
		end
		in_valid = 1'b0;

		while (median_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Checked %0d results from %0d directed and %0d random samples;",
			results_seen, ROWS, RANDOM_ITEMS);
		$display("%0d samples fill the store, %0d came back rejected once it was full.",
			CAP, rejects_seen);
		if (errors == 0)
			$display("running_median_tracker_top verification clean");
		else
			$display("running_median_tracker_top verification failed");
		$finish;
	end

endmodule
